// ----- design/htc_pkg.sv -----
// Package for the humidity and temperature calibration block.
// Holds item and register types, widths, register indexes and the divider step.
// No dependencies.
package htc_pkg;

    // Field and datapath widths
    localparam int RAW_W = 16;               // raw readings and raw points
    localparam int MAG_W = 16;               // magnitude of a raw difference
    localparam int REF_W = 7;                // reference in whole units
    localparam int RD_W  = 11;               // magnitude of reference span times ten
    localparam int OFF_W = 11;               // low reference times ten
    localparam int NUM_W = MAG_W + RD_W;     // numerator and quotient magnitude
    localparam int DVS_W = 16;               // divisor magnitude (raw span)
    localparam int SUM_W = NUM_W + 2;        // signed quotient plus offset
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_REF_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_REF_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_REF_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_REF_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_RAW_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_RAW_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_RAW_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_RAW_HIGH = 3'd7;

    // Saturation limits
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_humidity;
        logic signed [RAW_W-1:0] raw_temperature;
    } t_in_item;

    typedef struct packed {
        logic signed [RAW_W-1:0] humidity_tenths;
        logic signed [RAW_W-1:0] temperature_tenths;
        logic                    humidity_fault;
        logic                    temperature_fault;
    } t_out_item;

    typedef struct packed {
        logic [7:0]              hum_ref_low_x2;
        logic [7:0]              hum_ref_high_x2;
        logic [9:0]              temp_ref_low_x8;
        logic [9:0]              temp_ref_high_x8;
        logic signed [RAW_W-1:0] hum_raw_low;
        logic signed [RAW_W-1:0] hum_raw_high;
        logic signed [RAW_W-1:0] temp_raw_low;
        logic signed [RAW_W-1:0] temp_raw_high;
    } t_cfg;

    // One channel on its way through the divider cells
    typedef struct packed {
        logic [DVS_W-1:0] rem;    // partial remainder
        logic [NUM_W-1:0] nq;     // dividend bits shifting out, quotient bits in
        logic [DVS_W-1:0] dvs;    // divisor magnitude
        logic             neg;    // quotient is negated at the end
        logic             fault;  // zero span
        logic [OFF_W-1:0] off;    // low reference times ten
    } t_lane;

    typedef struct packed {
        t_lane hum;
        t_lane temp;
    } t_div_data;

    // One restoring division step: one quotient bit
    function automatic t_lane div_step(input t_lane l);
        t_lane          r;
        logic [DVS_W:0] trial;
        logic           qb;
        r     = l;
        trial = {l.rem, l.nq[NUM_W-1]};
        qb    = (trial >= {1'b0, l.dvs});
        if (qb) begin
            r.rem = DVS_W'(trial - {1'b0, l.dvs});
        end else begin
            r.rem = trial[DVS_W-1:0];
        end
        r.nq = {l.nq[NUM_W-2:0], qb};
        return r;
    endfunction

endpackage

// ----- design/htc_front.sv -----
// Front end of the calibration pipeline: differences, magnitudes and product.
// Two register stages; feeds the first divider cell. Depends on htc_pkg.
module htc_front import htc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_div_data o_data
);

    typedef struct packed {
        logic [MAG_W-1:0] mag_diff;
        logic [RD_W-1:0]  mag_rd;
        logic [DVS_W-1:0] dvs;
        logic             neg;
        logic             fault;
        logic [OFF_W-1:0] off;
    } t_pre;

    // Differences, spans and their magnitudes for one channel
    function automatic t_pre prep(
        input logic signed [RAW_W-1:0] raw,
        input logic signed [RAW_W-1:0] lo,
        input logic signed [RAW_W-1:0] hi,
        input logic [REF_W-1:0]        ref_lo,
        input logic [REF_W-1:0]        ref_hi
    );
        t_pre                   p;
        logic signed [RAW_W:0]  diff;
        logic signed [RAW_W:0]  span;
        logic signed [REF_W:0]  rdiff;
        logic signed [RD_W:0]   rd;
        diff    = {raw[RAW_W-1], raw} - {lo[RAW_W-1], lo};
        span    = {hi[RAW_W-1], hi} - {lo[RAW_W-1], lo};
        rdiff   = {1'b0, ref_hi} - {1'b0, ref_lo};
        rd      = {{(RD_W-REF_W){rdiff[REF_W]}}, rdiff} * (RD_W+1)'(10);
        p.mag_diff = diff[RAW_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
        p.mag_rd   = rd[RD_W] ? RD_W'(-rd) : rd[RD_W-1:0];
        p.dvs      = span[RAW_W] ? DVS_W'(-span) : span[DVS_W-1:0];
        p.neg      = diff[RAW_W] ^ rd[RD_W] ^ span[RAW_W];
        p.fault    = (span == '0);
        p.off      = {{(OFF_W-REF_W){1'b0}}, ref_lo} * OFF_W'(10);
        return p;
    endfunction

    // Product of magnitudes starts the division lane
    function automatic t_lane start_lane(input t_pre p);
        t_lane l;
        l.rem   = '0;
        l.nq    = {{RD_W{1'b0}}, p.mag_diff} * {{MAG_W{1'b0}}, p.mag_rd};
        l.dvs   = p.dvs;
        l.neg   = p.neg;
        l.fault = p.fault;
        l.off   = p.off;
        return l;
    endfunction

    logic r_valid_a;
    logic r_valid_b;
    t_pre r_hum_a, n_hum_a;
    t_pre r_temp_a, n_temp_a;
    t_div_data r_data_b, n_data_b;

    // Stage A: subtract and take magnitudes
    always_comb begin
        n_hum_a  = prep(i_item.raw_humidity, i_cfg.hum_raw_low, i_cfg.hum_raw_high,
                        i_cfg.hum_ref_low_x2[7:1], i_cfg.hum_ref_high_x2[7:1]);
        n_temp_a = prep(i_item.raw_temperature, i_cfg.temp_raw_low, i_cfg.temp_raw_high,
                        i_cfg.temp_ref_low_x8[9:3], i_cfg.temp_ref_high_x8[9:3]);
    end

    // Stage B: one multiply per channel
    always_comb begin
        n_data_b.hum  = start_lane(r_hum_a);
        n_data_b.temp = start_lane(r_temp_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_accept;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hum_a  <= n_hum_a;
        r_temp_a <= n_temp_a;
        r_data_b <= n_data_b;
    end

    assign o_valid = r_valid_b;
    assign o_data  = r_data_b;

endmodule

// ----- design/htc_cell.sv -----
// One divider cell: a single quotient bit for both channels, then a register.
// Cells are chained, one per quotient bit. Depends on htc_pkg.
module htc_cell import htc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_data i_data,
    output logic      o_valid,
    output t_div_data o_data
);

    logic      r_valid;
    t_div_data r_data, n_data;

    // Restoring step on each lane
    always_comb begin
        n_data.hum  = div_step(i_data.hum);
        n_data.temp = div_step(i_data.temp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- design/htc_back.sv -----
// Back end: applies sign and offset, saturates, handles zero span.
// Registers the result and its strobe. Depends on htc_pkg.
module htc_back import htc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_data i_data,
    output logic      o_valid,
    output t_out_item o_result
);

    // Signed quotient plus offset, clamped to 16 bits; 0 on fault
    function automatic logic signed [RAW_W-1:0] finish(input t_lane l);
        logic signed [SUM_W-1:0] s;
        logic signed [RAW_W-1:0] v;
        if (l.neg) begin
            s = {{(SUM_W-OFF_W){1'b0}}, l.off} - {2'b0, l.nq};
        end else begin
            s = {{(SUM_W-OFF_W){1'b0}}, l.off} + {2'b0, l.nq};
        end
        if (l.fault) begin
            v = '0;
        end else if (s > SAT_MAX) begin
            v = SAT_MAX[RAW_W-1:0];
        end else if (s < SAT_MIN) begin
            v = SAT_MIN[RAW_W-1:0];
        end else begin
            v = s[RAW_W-1:0];
        end
        return v;
    endfunction

    logic      r_valid;
    t_out_item r_result, n_result;

    always_comb begin
        n_result.humidity_tenths    = finish(i_data.hum);
        n_result.temperature_tenths = finish(i_data.temp);
        n_result.humidity_fault     = i_data.hum.fault;
        n_result.temperature_fault  = i_data.temp.fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- design/humidity_temperature_calibration.sv -----
// Top level of the humidity and temperature calibration block.
// Holds the calibration registers and chains front end, divider cells and back end.
// Depends on htc_pkg, htc_front, htc_cell, htc_back.
//
// Converts a raw humidity and raw temperature pair to tenths by two-point linear
// interpolation. A pair is taken on every clock with i_start high and o_busy low;
// o_busy is high only while reset is held, so a new pair may follow every cycle.
// There are NUM_W+3 = 30 register stages: one divider cell per quotient bit (27),
// two front stages (difference, multiply) and one output stage. The first stage
// loads at the edge that takes the pair, and the pair then moves through the front
// stages, the divider cells and the output stage in order. Each result is on
// o_result for exactly one cycle with o_valid high, in input order;
// the receiver cannot stall it. Calibration registers are written through
// i_cfg_we/i_cfg_index/i_cfg_data and must only be changed while no pair is in
// flight.
module humidity_temperature_calibration import htc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in_item              i_item,
    output logic                  o_valid,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic accept;

    logic      chain_valid [NUM_W+1];
    t_div_data chain_data  [NUM_W+1];

    assign o_busy = ~i_rst_n;
    assign accept = i_start & ~o_busy;

    // Calibration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HUM_REF_LOW:   r_cfg.hum_ref_low_x2   <= i_cfg_data[7:0];
                CFG_HUM_REF_HIGH:  r_cfg.hum_ref_high_x2  <= i_cfg_data[7:0];
                CFG_TEMP_REF_LOW:  r_cfg.temp_ref_low_x8  <= i_cfg_data[9:0];
                CFG_TEMP_REF_HIGH: r_cfg.temp_ref_high_x8 <= i_cfg_data[9:0];
                CFG_HUM_RAW_LOW:   r_cfg.hum_raw_low      <= i_cfg_data;
                CFG_HUM_RAW_HIGH:  r_cfg.hum_raw_high     <= i_cfg_data;
                CFG_TEMP_RAW_LOW:  r_cfg.temp_raw_low     <= i_cfg_data;
                CFG_TEMP_RAW_HIGH: r_cfg.temp_raw_high    <= i_cfg_data;
            endcase
        end
    end

    // Differences and product
    htc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_valid  (chain_valid[0]),
        .o_data   (chain_data[0])
    );

    // Divider: one cell per quotient bit
    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        htc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    // Sign, offset and saturation
    htc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid[NUM_W]),
        .i_data   (chain_data[NUM_W]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
